// ----- rtl/core/sukt_pkg.sv -----
package sukt_pkg;

	// Field widths fixed by the item format.
	localparam int KEY_W = 31;
	localparam int PAY_W = 32;
	localparam int POS_W = 4;
	localparam int CNT_W = 5;
	localparam int ST_W  = 2;

	// Function codes of an input word.
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	// Status codes of a result word.
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_DUP   = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic             func;
		logic [KEY_W-1:0] record_key;
		logic [PAY_W-1:0] record_payload;
		logic [POS_W-1:0] read_position;
	} sukt_req_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [POS_W-1:0] slot;
		logic [KEY_W-1:0] out_key;
		logic [PAY_W-1:0] out_payload;
		logic [CNT_W-1:0] entry_count;
	} sukt_rsp_t;

	// One stored record, handed from cell to cell on a shift.
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} sukt_rec_t;

	// Compare flags of one cell against the incoming key.
	typedef struct packed {
		logic eq;
		logic lt;
		logic gt;
	} sukt_cmp_t;

endpackage

// ----- rtl/core/sukt_if.sv -----
interface sukt_req_if import sukt_pkg::*; ();
	logic      valid;
	logic      ready;
	sukt_req_t word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

interface sukt_rsp_if import sukt_pkg::*; ();
	logic      valid;
	logic      ready;
	sukt_rsp_t word;

	modport source (output valid, output word, input ready);
	modport sink (input valid, input word, output ready);
endinterface

// ----- rtl/core/sorted_unique_key_table.sv -----
// Sorted table of unique keys, held in a row of compare-and-shift cells.
// Input channel req: one word per command. func selects insert (key and
// payload are stored in ascending key order) or read (the record at
// read_position is returned). Output channel rsp: exactly one result word
// per command, with status, slot, the record read and the entry count.
// Every cell compares its key with the incoming key in parallel; the
// compare flags give the duplicate check and the insert position, and on
// an insert every cell whose left neighbor holds a larger key takes its record.
// The result word is registered and valid in the cycle after acceptance.
// Throughput is one command per cycle while rsp.ready stays high: the
// result register reloads at the edge that hands on the previous word.
// The critical path is one key compare in every cell plus the one-hot
// encode of the position over DEPTH cells.
// When the receiver stalls, the result word holds and req.ready drops
// until the word is taken; no command is lost.
// Reset clears the entry count and the result valid flag; stored records
// need no clearing, since only occupied cells are ever read.
module sorted_unique_key_table import sukt_pkg::*; #(
	parameter int DEPTH = 16
) (
	input logic       clk,
	input logic       arst_n,
	sukt_req_if.sink  req,
	sukt_rsp_if.source rsp
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int IW   = $clog2(DEPTH);
	localparam int RD_N = (DEPTH < 16) ? DEPTH : 16;

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_after;
	logic          rsp_valid_q;
	sukt_rsp_t     rsp_q;
	sukt_rsp_t     rsp_d;

	sukt_rec_t       new_rec;
	sukt_rec_t       cell_rec [DEPTH];
	sukt_cmp_t       cell_cmp [DEPTH];
	logic [DEPTH-1:0] occ;
	logic [DEPTH-1:0] eq_v;
	logic [DEPTH-1:0] lt_v;
	logic [DEPTH-1:0] here_v;
	logic [DEPTH-1:0] hit_v;
	logic [IW-1:0]    hit_idx;

	logic accept;
	logic is_insert;
	logic dup;
	logic full;
	logic commit;
	logic in_range;

	logic [IW+3:0]   slot_ext;
	logic [CW+3:0]   rp_ext;
	logic [CW+3:0]   cnt_ext;
	logic [CW+4:0]   ec_ext;
	sukt_rec_t       rd_rec;

	// Handshake: a new word enters whenever the result register is free or drained.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign new_rec.key     = req.word.record_key;
	assign new_rec.payload = req.word.record_payload;

	// Row of cells; cell i is occupied while i is below the entry count.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign occ[i]  = count_q > CW'(i);
		assign eq_v[i] = cell_cmp[i].eq;
		assign lt_v[i] = cell_cmp[i].lt;

		if (i == 0) begin : g_first
			assign here_v[i] = !lt_v[i];
			sukt_cell u_cell (
				.clk      (clk),
				.new_rec  (new_rec),
				.left_rec ('0),
				.left_cmp ('0),
				.occupied (occ[i]),
				.commit   (commit),
				.rec_q    (cell_rec[i]),
				.cmp      (cell_cmp[i])
			);
		end else begin : g_rest
			assign here_v[i] = lt_v[i-1] && !lt_v[i];
			sukt_cell u_cell (
				.clk      (clk),
				.new_rec  (new_rec),
				.left_rec (cell_rec[i-1]),
				.left_cmp (cell_cmp[i-1]),
				.occupied (occ[i]),
				.commit   (commit),
				.rec_q    (cell_rec[i]),
				.cmp      (cell_cmp[i])
			);
		end
	end

	// Insert decision.
	assign is_insert = req.word.func == FUNC_INSERT;
	assign dup       = |eq_v;
	assign full      = count_q == CW'(DEPTH);
	assign commit    = accept && is_insert && !dup && !full;

	// The position reported is the matching cell on a duplicate, else the insert point.
	assign hit_v = dup ? eq_v : here_v;

	sukt_enc #(.N(DEPTH)) u_enc (
		.hit (hit_v),
		.idx (hit_idx)
	);

	assign slot_ext = {4'b0, hit_idx};

	// Read select: read_position reaches the first sixteen cells only.
	always_comb begin
		rd_rec = '0;
		for (int i = 0; i < RD_N; i++) begin
			if (req.word.read_position == POS_W'(i)) begin
				rd_rec = cell_rec[i];
			end
		end
	end

	assign rp_ext   = {{CW{1'b0}}, req.word.read_position};
	assign cnt_ext  = {4'b0, count_q};
	assign in_range = rp_ext < cnt_ext;

	assign count_after = commit ? count_q + CW'(1) : count_q;
	assign ec_ext      = {5'b0, count_after};

	// Result word.
	always_comb begin
		rsp_d             = '0;
		rsp_d.entry_count = ec_ext[CNT_W-1:0];
		if (is_insert) begin
			if (dup) begin
				rsp_d.status = ST_DUP;
				rsp_d.slot   = slot_ext[POS_W-1:0];
			end else if (full) begin
				rsp_d.status = ST_FULL;
			end else begin
				rsp_d.status = ST_OK;
				rsp_d.slot   = slot_ext[POS_W-1:0];
			end
		end else begin
			rsp_d.slot = req.word.read_position;
			if (in_range) begin
				rsp_d.status      = ST_OK;
				rsp_d.out_key     = rd_rec.key;
				rsp_d.out_payload = rd_rec.payload;
			end else begin
				rsp_d.status = ST_RANGE;
			end
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_after;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.word  = rsp_q;

endmodule

// ----- rtl/core/sukt_cell.sv -----
module sukt_cell import sukt_pkg::*; (
	input  logic      clk,
	input  sukt_rec_t new_rec,
	input  sukt_rec_t left_rec,
	input  sukt_cmp_t left_cmp,
	input  logic      occupied,
	input  logic      commit,
	output sukt_rec_t rec_q,
	output sukt_cmp_t cmp
);

	// Compare the stored key with the incoming one; an empty cell reports nothing.
	always_comb begin
		cmp.eq = occupied && (rec_q.key == new_rec.key);
		cmp.lt = occupied && (rec_q.key < new_rec.key);
		cmp.gt = occupied && (rec_q.key > new_rec.key);
	end

	// On an insert the cell takes its left neighbor when that one moves up,
	// and takes the new record when it is the first cell with a larger key
	// or the first empty one. Cells past the end may load anything.
	always_ff @(posedge clk) begin
		if (commit) begin
			if (left_cmp.gt) begin
				rec_q <= left_rec;
			end else if (!occupied || cmp.gt) begin
				rec_q <= new_rec;
			end
		end
	end

endmodule

// ----- rtl/core/sukt_enc.sv -----
module sukt_enc #(
	parameter int N = 16
) (
	input  logic [N-1:0]         hit,
	output logic [$clog2(N)-1:0] idx
);

	localparam int IW = $clog2(N);

	// One-hot to binary: at most one bit of hit is set.
	always_comb begin
		idx = '0;
		for (int i = 0; i < N; i++) begin
			if (hit[i]) begin
				idx = idx | IW'(i);
			end
		end
	end

endmodule

// ----- rtl/core/sukt_checker.sv -----
module sukt_checker import sukt_pkg::*; #(
	parameter int DEPTH = 16
) (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_ready,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input sukt_rsp_t rsp_word
);

	// Every accepted command shows a result word in the next cycle.
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("accepted command gave no result word");

	// A stalled result word stays and holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
		else $error("stalled result word changed");

	// Only a successful command carries record contents.
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.status != ST_OK |->
		rsp_word.out_key == '0 && rsp_word.out_payload == '0)
		else $error("failed command returned record contents");

	// A full-table reject reports slot zero and a full count.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_word.status == ST_FULL |->
		rsp_word.slot == '0 && rsp_word.entry_count == CNT_W'(DEPTH))
		else $error("full-table reject with wrong slot or count");

endmodule

bind sorted_unique_key_table sukt_checker #(.DEPTH(DEPTH)) u_sukt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_word  (rsp.word)
);
